// File: src/vtpl_pkg.sv
// Shared types, constants and the page count function of the virtual texture page locator.
// No dependencies; every other file imports this package.
package vtpl_pkg;

  localparam int MAX_LEVELS         = 16;
  localparam int PAGE_TEXELS        = 128;
  localparam int PAGE_PAYLOAD_BYTES = 73984;

  localparam int DIM_W   = 15;
  localparam int LEVEL_W = 4;
  localparam int PAGE_W  = 10;
  localparam int CNT_W   = 5;
  localparam int OFF_W   = 40;

  localparam int HEADER_BYTES = 24;
  localparam int TABLE_BYTES  = 8;

  localparam int PG_W   = $clog2(((2 ** DIM_W) - 1 + PAGE_TEXELS - 1) / PAGE_TEXELS + 1);
  localparam int MUL_W  = (PG_W > PAGE_W) ? PG_W : PAGE_W;
  localparam int ACC_W  = 2 * MUL_W + $clog2(MAX_LEVELS + 2);
  localparam int PPB_W  = $clog2(PAGE_PAYLOAD_BYTES + 1);
  localparam int PROD_W = ACC_W + PPB_W;
  localparam int SUM_W  = (PROD_W + 1 > OFF_W + 1) ? PROD_W + 1 : OFF_W + 1;
  localparam int BASE_W = $clog2(HEADER_BYTES + TABLE_BYTES * MAX_LEVELS + 1);

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd2;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_LEVEL = 2'd1,
    ST_PAGE  = 2'd2
  } status_t;

  typedef struct packed {
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
    logic [LEVEL_W-1:0] remain;
    logic               done;
    status_t            status;
    logic [PAGE_W-1:0]  col;
    logic [PAGE_W-1:0]  row;
    logic [ACC_W-1:0]   acc;
  } tok_t;

  function automatic logic [PG_W-1:0] pages_along(input logic [DIM_W-1:0] d);
    logic [DIM_W:0] t;
    t = (d == '0) ? (DIM_W+1)'(1) : {1'b0, d};
    t = t + (DIM_W+1)'(PAGE_TEXELS - 1);
    return PG_W'(t / PAGE_TEXELS);
  endfunction

endpackage

// File: src/vtpl_cell.sv
// One cell of the level chain: it handles the mip level of its place in the row.
// Depends on vtpl_pkg for the token type and the page count function.
module vtpl_cell import vtpl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic in_valid,
  input  tok_t in_tok,
  output logic out_valid,
  output tok_t out_tok
);

  logic [PG_W-1:0]    pw;
  logic [PG_W-1:0]    ph;
  logic               active;
  logic               here;
  logic               page_ok;
  logic [MUL_W-1:0]   op_a;
  logic [MUL_W-1:0]   op_b;
  logic [2*MUL_W-1:0] prod;
  logic [PAGE_W-1:0]  addend;
  tok_t               tok_nxt;
  logic               valid_r;
  tok_t               tok_r;

  always_comb begin
    pw      = pages_along(in_tok.width);
    ph      = pages_along(in_tok.height);
    active  = !in_tok.done && (in_tok.status == ST_OK);
    here    = (in_tok.remain == '0);
    page_ok = (MUL_W'(in_tok.col) < MUL_W'(pw)) && (MUL_W'(in_tok.row) < MUL_W'(ph));
    op_a    = here ? MUL_W'(in_tok.row) : MUL_W'(pw);
    op_b    = here ? MUL_W'(pw) : MUL_W'(ph);
    prod    = op_a * op_b;
    addend  = here ? in_tok.col : '0;

    tok_nxt        = in_tok;
    tok_nxt.width  = in_tok.width >> 1;
    tok_nxt.height = in_tok.height >> 1;
    if (active) begin
      if (!here) begin
        tok_nxt.acc    = in_tok.acc + ACC_W'(prod);
        tok_nxt.remain = in_tok.remain - LEVEL_W'(1);
      end else if (page_ok) begin
        tok_nxt.acc  = in_tok.acc + ACC_W'(prod) + ACC_W'(addend);
        tok_nxt.done = 1'b1;
      end else begin
        tok_nxt.status = ST_PAGE;
        tok_nxt.done   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tok_r <= tok_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_tok   = tok_r;

endmodule

// File: src/vtpl_scale.sv
// Final stages: page index times payload size plus header and table, saturated; 0 on error.
// Depends on vtpl_pkg for widths, the status type and the token type.
module vtpl_scale import vtpl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  tok_t              in_tok,
  input  logic [BASE_W-1:0] base,
  output logic              out_valid,
  output logic [OFF_W-1:0]  out_offset,
  output status_t           out_status
);

  logic              s1_valid_r;
  logic [PROD_W-1:0] s1_prod_r;
  status_t           s1_status_r;
  logic [SUM_W-1:0]  sum;
  logic [OFF_W-1:0]  off_nxt;
  logic              out_valid_r;
  logic [OFF_W-1:0]  offset_r;
  status_t           status_r;

  always_comb begin
    sum = SUM_W'(s1_prod_r) + SUM_W'(base);
    if (s1_status_r != ST_OK) begin
      off_nxt = '0;
    end else if (sum > SUM_W'({OFF_W{1'b1}})) begin
      off_nxt = {OFF_W{1'b1}};
    end else begin
      off_nxt = OFF_W'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r  <= in_valid;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_prod_r   <= PROD_W'(in_tok.acc) * PROD_W'(PAGE_PAYLOAD_BYTES);
      s1_status_r <= in_tok.status;
      offset_r    <= off_nxt;
      status_r    <= s1_status_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_offset = offset_r;
  assign out_status = status_r;

endmodule

// File: src/virtual_texture_page_locator.sv
// Virtual texture page locator: a request enters a row of one cell per mip level,
// moves from cell to cell, then through a payload multiply and an output register,
// and one request is taken every cycle while the output is not stalled.
// Depends on vtpl_pkg, vtpl_cell, vtpl_scale.
module virtual_texture_page_locator import vtpl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [23:0]          in_tdata,   // level [3:0], page_col [13:4], page_row [23:14]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [47:0]          out_tdata,  // byte_offset [39:0], status [41:40], zeros above
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_W-1:0]     cfg_data
);

  logic [DIM_W-1:0]  width_r;
  logic [DIM_W-1:0]  height_r;
  logic [CNT_W-1:0]  levels_r;
  logic [CNT_W-1:0]  eff_cnt;
  logic [BASE_W-1:0] base;
  logic              en;
  logic [LEVEL_W-1:0] in_level;
  tok_t              chain_tok [MAX_LEVELS+1];
  logic [MAX_LEVELS:0] chain_valid;
  logic [OFF_W-1:0]  res_offset;
  status_t           res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      levels_r <= CNT_W'(1);
    end else if (cfg_valid) begin
      if (cfg_index == CFG_WIDTH) begin
        width_r <= cfg_data;
      end else if (cfg_index == CFG_HEIGHT) begin
        height_r <= cfg_data;
      end else if (cfg_index == CFG_LEVELS) begin
        levels_r <= cfg_data[CNT_W-1:0];
      end
    end
  end

  always_comb begin
    eff_cnt  = (levels_r > CNT_W'(MAX_LEVELS)) ? CNT_W'(MAX_LEVELS) : levels_r;
    base     = BASE_W'(HEADER_BYTES) + BASE_W'(eff_cnt) * BASE_W'(TABLE_BYTES);
    en       = !out_tvalid || out_tready;
    in_level = in_tdata[3:0];
  end

  assign chain_valid[0] = in_tvalid;
  assign chain_tok[0]   = '{width:  width_r,
                            height: height_r,
                            remain: in_level,
                            done:   1'b0,
                            status: (CNT_W'(in_level) >= eff_cnt) ? ST_LEVEL : ST_OK,
                            col:    in_tdata[13:4],
                            row:    in_tdata[23:14],
                            acc:    '0};

  assign in_tready = en;

  for (genvar i = 0; i < MAX_LEVELS; i++) begin : g_cell
    vtpl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (chain_valid[i]),
      .in_tok    (chain_tok[i]),
      .out_valid (chain_valid[i+1]),
      .out_tok   (chain_tok[i+1])
    );
  end

  vtpl_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (chain_valid[MAX_LEVELS]),
    .in_tok     (chain_tok[MAX_LEVELS]),
    .base       (base),
    .out_valid  (out_tvalid),
    .out_offset (res_offset),
    .out_status (res_status)
  );

  assign out_tdata = {6'b0, res_status, res_offset};

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_status != ST_OK) |-> res_offset == '0)
    else $error("non-zero offset with an error status");

  a_ok_above_base: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (res_status == ST_OK) |-> res_offset >= OFF_W'(base))
    else $error("offset below the header and page table");

  a_chain_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    chain_valid[MAX_LEVELS] && (chain_tok[MAX_LEVELS].status == ST_OK)
      |-> chain_tok[MAX_LEVELS].done)
    else $error("request left the cell row without reaching its level");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output transaction offered straight after reset");

endmodule
